// ===== rtl/core/lobpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Link occupancy BPR package
// Shared types and codes for the per-link occupancy and delay table.
// ----------------------------------------------------------------------------
package lobpr_pkg;

    // Item kinds. Codes above KIND_UPDATE read a link like a query.
    localparam logic [2:0] KIND_LOAD   = 3'd0;
    localparam logic [2:0] KIND_ENTER  = 3'd1;
    localparam logic [2:0] KIND_EXIT   = 3'd2;
    localparam logic [2:0] KIND_REMOVE = 3'd3;
    localparam logic [2:0] KIND_UPDATE = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_JAM   = 2'd0;
    localparam logic [1:0] CFG_ALPHA = 2'd1;
    localparam logic [1:0] CFG_EDGES = 2'd2;

    // One table word per link.
    typedef struct packed {
        logic [15:0] occ;
        logic        act;
        logic [15:0] ema;
        logic [23:0] stor;
        logic [23:0] ff;
        logic [25:0] tt;
    } lobpr_entry_t;

    // Request to the shared divider. The partial remainder must start below
    // the divisor; low holds the dividend bits still to be shifted in.
    typedef struct packed {
        logic        start;
        logic [4:0]  steps;
        logic [23:0] rem;
        logic [23:0] low;
        logic [23:0] divisor;
    } lobpr_div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [23:0] quot;
    } lobpr_div_rsp_t;

endpackage

// ===== rtl/core/lobpr_div.sv =====
// ----------------------------------------------------------------------------
// Link occupancy BPR divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lobpr_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lobpr_pkg::lobpr_div_req_t req,
    output lobpr_pkg::lobpr_div_rsp_t rsp
);
    import lobpr_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [23:0] rem_reg;
    logic [23:0] low_reg;
    logic [23:0] div_reg;
    logic [23:0] quot_reg;
    logic [24:0] trial;
    logic        fits;

    assign trial = {rem_reg, low_reg[23]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
                rem_reg  <= req.rem;
                low_reg  <= req.low;
                div_reg  <= req.divisor;
                quot_reg <= '0;
            end else if (busy_reg) begin
                if (fits) begin
                    rem_reg  <= 24'(trial - {1'b0, div_reg});
                    quot_reg <= {quot_reg[22:0], 1'b1};
                end else begin
                    rem_reg  <= trial[23:0];
                    quot_reg <= {quot_reg[22:0], 1'b0};
                end
                low_reg <= {low_reg[22:0], 1'b0};
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp = '{busy: busy_reg, done: done_reg, quot: quot_reg};

endmodule

// ===== rtl/core/lobpr_table.sv =====
// ----------------------------------------------------------------------------
// Link occupancy BPR table
// Single-port-write, registered-read memory holding one word per link.
// ----------------------------------------------------------------------------
module lobpr_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                   aclk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  lobpr_pkg::lobpr_entry_t wdata,
    input  logic [AW-1:0]          raddr,
    output lobpr_pkg::lobpr_entry_t rdata
);
    import lobpr_pkg::*;

    lobpr_entry_t mem [DEPTH];
    lobpr_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/link_occupancy_bpr_delay_table_unit.sv =====
// ----------------------------------------------------------------------------
// Link occupancy BPR delay table unit
// Per-link occupancy, storage, free-flow and travel time with BPR delay.
// ----------------------------------------------------------------------------
// An item is read from the table, changed in ST_EXEC and written back as its kind
// needs; an off-table item goes straight to the result. Enter and force remove
// compute the BPR travel time, with the 18-step divide for occ/storage where needed.
// The next item is taken from the cycle after the result is registered. Update walks
// all LINK_COUNT entries, an active one with up to two serial divides, then reads the
// link if it is valid. Reset: a clearing pass zeroes every table word first.
// ----------------------------------------------------------------------------
module link_occupancy_bpr_delay_table_unit #(
    parameter int LINK_COUNT = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Input item channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [9:0]  s_edge_req,
    input  logic [39:0] s_now_time,
    input  logic [23:0] s_free_flow_time,
    input  logic [15:0] s_link_capacity,
    input  logic [15:0] s_link_length,
    // Result channel.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [39:0] m_exit_time,
    output logic [25:0] m_travel_time,
    output logic [15:0] m_occupancy,
    output logic [15:0] m_cong_level,
    output logic        m_edge_valid
);
    import lobpr_pkg::*;

    localparam int AW = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(LINK_COUNT - 1);
    localparam logic [31:0] LINK_COUNT_W = 32'(LINK_COUNT);
    // Storage saturates once len*cap*jam/2^14 reaches 25 * 2^24.
    localparam logic [33:0] STOR_SAT_X = 34'd419430400;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_RD, ST_EXEC, ST_LMUL1, ST_LMUL2, ST_LDIV,
        ST_BPR, ST_BWAIT, ST_SQ1, ST_SQ2, ST_FAC, ST_TT, ST_EMA, ST_EWAIT,
        ST_EMUL, ST_EUPD, ST_WR, ST_WRD, ST_WGOT, ST_OUT
    } state_t;

    // Configuration registers. Writes land only while the unit is idle.
    logic [15:0] jam_reg;
    logic [15:0] alpha_reg;
    logic [10:0] edges_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jam_reg   <= 16'd8738;
            alpha_reg <= 16'd6554;
            edges_reg <= 11'd1024;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_JAM:   jam_reg   <= cfg_data;
                CFG_ALPHA: alpha_reg <= cfg_data;
                CFG_EDGES: edges_reg <= cfg_data[10:0];
                default:   ;
            endcase
        end
    end

    // Control and working registers of the sequencer.
    state_t         state_reg;
    logic           walk_reg;
    logic [AW-1:0]  addr_reg;
    logic [2:0]     kind_reg;
    logic [9:0]     edge_reg;
    logic [39:0]    now_reg;
    logic [23:0]    ffin_reg;
    logic [15:0]    cap_reg;
    logic [15:0]    len_reg;
    logic           inr_reg;
    lobpr_entry_t   ent_reg;
    logic [31:0]    p1_reg;
    logic [33:0]    x_reg;
    logic [17:0]    vc_reg;
    logic [18:0]    v2_reg;
    logic [20:0]    v4_reg;
    logic [17:0]    fac_reg;
    logic [15:0]    ratio_reg;
    logic [15:0]    dlt_reg;
    logic           up_reg;
    lobpr_div_req_t div_req_reg;
    lobpr_div_rsp_t div_rsp;

    logic           m_valid_reg;
    logic [39:0]    m_exit_reg;
    logic [25:0]    m_tt_reg;
    logic [15:0]    m_occ_reg;
    logic [15:0]    m_ema_reg;
    logic           m_ev_reg;

    // A register write is taken only between items, when no item is offered.
    assign cfg_ready = (state_reg == ST_IDLE) && !s_valid;

    // Table memory: one word per link, with a registered read.
    logic           mem_we;
    lobpr_entry_t   mem_wdata;
    lobpr_entry_t   rdata;

    assign mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WR);
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : ent_reg;

    lobpr_table #(.DEPTH(LINK_COUNT), .AW(AW)) u_table (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (addr_reg),
        .wdata (mem_wdata),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    // The occ/storage and tt/ff divides share this one serial divider.
    lobpr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req_reg),
        .rsp     (div_rsp)
    );

    // A link is valid when below both the programmed count and the depth.
    logic in_range_now;
    assign in_range_now = ({1'b0, s_edge_req} < edges_reg) &&
                          ({22'd0, s_edge_req} < LINK_COUNT_W);

    // Occupancy after an enter (saturating) or an exit (floored at zero).
    logic [15:0] occ_inc;
    logic [15:0] occ_dec;
    assign occ_inc = (rdata.occ == 16'hFFFF) ? rdata.occ : rdata.occ + 16'd1;
    assign occ_dec = (rdata.occ == 16'd0) ? rdata.occ : rdata.occ - 16'd1;

    // Table word as changed by the addressed item.
    lobpr_entry_t exec_ent;
    always_comb begin
        exec_ent = rdata;
        case (kind_reg)
            KIND_ENTER: begin
                exec_ent.occ = occ_inc;
                if (occ_inc == 16'd1) begin
                    exec_ent.act = 1'b1;
                end
            end
            KIND_EXIT, KIND_REMOVE: begin
                exec_ent.occ = occ_dec;
            end
            default: ;
        endcase
    end

    // Table word seen by the update walk. An emptied active link returns to
    // free flow and leaves the active set.
    lobpr_entry_t walk_ent;
    always_comb begin
        walk_ent = rdata;
        if (rdata.act && (rdata.occ == 16'd0)) begin
            walk_ent.tt  = {2'd0, rdata.ff};
            walk_ent.act = 1'b0;
        end
    end

    // Load arithmetic: the lane length and capacity have floors.
    logic [15:0] len_eff;
    logic [15:0] cap_eff;
    logic [31:0] p1_next;
    logic [47:0] p2;
    assign len_eff = (len_reg < 16'd50) ? 16'd50 : len_reg;
    assign cap_eff = (cap_reg < 16'd1600) ? 16'd1600 : cap_reg;
    assign p1_next = len_eff * cap_eff;
    assign p2      = p1_reg * jam_reg;

    // Storage is x/25 with x = len*cap*jam/2^14. Below the saturation point x
    // fits in 29 bits, where multiplying by 2^34/25 rounded up and dropping
    // 34 bits gives the exact floor.
    logic [58:0] stor_prod;
    logic [23:0] stor_next;
    assign stor_prod = x_reg[28:0] * 30'd687194768;
    assign stor_next = (x_reg >= STOR_SAT_X) ? 24'hFF_FFFF : stor_prod[57:34];

    // BPR arithmetic. The link counts as congested once occ/storage >= 0.8,
    // which is occ*320 >= storage in exact integers.
    logic [24:0] occ_x320;
    logic [35:0] sq1;
    logic [37:0] sq2;
    logic [36:0] fprod;
    logic [41:0] ttprod;
    assign occ_x320 = {1'b0, ent_reg.occ, 8'd0} + {3'd0, ent_reg.occ, 6'd0};
    assign sq1      = vc_reg * vc_reg;
    assign sq2      = v2_reg * v2_reg;
    assign fprod    = v4_reg * 16'd9830;
    assign ttprod   = ent_reg.ff * fac_reg;

    // EMA step toward the tt/ff ratio.
    logic [15:0] ema_diff;
    logic [31:0] dprod;
    assign ema_diff = (ratio_reg >= ent_reg.ema) ? ratio_reg - ent_reg.ema
                                                 : ent_reg.ema - ratio_reg;
    assign dprod    = alpha_reg * ema_diff;

    // Exit time: now plus the travel time, or plus one second off the table.
    logic [40:0] exit_sum;
    logic [39:0] exit_sat;
    assign exit_sum = {1'b0, now_reg} + (inr_reg ? {15'd0, ent_reg.tt} : 41'd256);
    assign exit_sat = exit_sum[40] ? 40'hFF_FFFF_FFFF : exit_sum[39:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            addr_reg          <= '0;
            walk_reg          <= 1'b0;
            div_req_reg.start <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            // A result leaving while the next one is written keeps valid high.
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    // Zero one word a cycle; occupancy, marks and EMA start at zero.
                    if (addr_reg == LAST_IDX) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        kind_reg <= s_kind;
                        edge_reg <= s_edge_req;
                        now_reg  <= s_now_time;
                        ffin_reg <= s_free_flow_time;
                        cap_reg  <= s_link_capacity;
                        len_reg  <= s_link_length;
                        inr_reg  <= in_range_now;
                        if (s_kind == KIND_UPDATE) begin
                            // The walk runs even when the addressed link is invalid.
                            walk_reg  <= 1'b1;
                            addr_reg  <= '0;
                            state_reg <= ST_WRD;
                        end else if (!in_range_now) begin
                            state_reg <= ST_OUT;
                        end else begin
                            addr_reg  <= AW'(s_edge_req);
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_RD: begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    ent_reg <= exec_ent;
                    case (kind_reg)
                        KIND_LOAD: begin
                            state_reg <= ST_LMUL1;
                        end
                        KIND_ENTER: begin
                            state_reg <= ST_BPR;
                        end
                        KIND_EXIT: begin
                            state_reg <= ST_WR;
                        end
                        KIND_REMOVE: begin
                            state_reg <= ST_BPR;
                        end
                        default: begin
                            state_reg <= ST_OUT;
                        end
                    endcase
                end
                ST_LMUL1: begin
                    p1_reg    <= p1_next;
                    state_reg <= ST_LMUL2;
                end
                ST_LMUL2: begin
                    x_reg     <= p2[47:14];
                    state_reg <= ST_LDIV;
                end
                ST_LDIV: begin
                    ent_reg   <= '{occ: ent_reg.occ, act: ent_reg.act, ema: ent_reg.ema,
                                   stor: stor_next, ff: ffin_reg, tt: {2'd0, ffin_reg}};
                    state_reg <= ST_WR;
                end
                ST_BPR: begin
                    if ((ent_reg.stor == 24'd0) || (occ_x320 < {1'b0, ent_reg.stor})) begin
                        ent_reg.tt <= {2'd0, ent_reg.ff};
                        state_reg  <= walk_reg ? ST_EMA : ST_WR;
                    end else if ({2'd0, ent_reg.occ, 6'd0} >= ent_reg.stor) begin
                        // The ratio is at least four; it clamps at two anyway.
                        vc_reg    <= 18'd131072;
                        state_reg <= ST_SQ1;
                    end else begin
                        div_req_reg <= '{start: 1'b1, steps: 5'd18,
                                         rem: {2'd0, ent_reg.occ, 6'd0}, low: 24'd0,
                                         divisor: ent_reg.stor};
                        state_reg   <= ST_BWAIT;
                    end
                end
                ST_BWAIT: begin
                    div_req_reg.start <= 1'b0;
                    if (div_rsp.done) begin
                        vc_reg    <= (div_rsp.quot[17:0] > 18'd131072) ? 18'd131072
                                                                       : div_rsp.quot[17:0];
                        state_reg <= ST_SQ1;
                    end
                end
                ST_SQ1: begin
                    v2_reg    <= sq1[34:16];
                    state_reg <= ST_SQ2;
                end
                ST_SQ2: begin
                    v4_reg    <= sq2[36:16];
                    state_reg <= ST_FAC;
                end
                ST_FAC: begin
                    fac_reg   <= 18'h10000 + fprod[33:16];
                    state_reg <= ST_TT;
                end
                ST_TT: begin
                    // The factor stays below 3.4, so the product fits in 26 bits.
                    ent_reg.tt <= ttprod[41:16];
                    state_reg  <= walk_reg ? ST_EMA : ST_WR;
                end
                ST_EMA: begin
                    if (ent_reg.ff == 24'd0) begin
                        state_reg <= ST_WR;
                    end else if (ent_reg.tt[25:2] >= ent_reg.ff) begin
                        ratio_reg <= 16'hFFFF;
                        state_reg <= ST_EMUL;
                    end else begin
                        div_req_reg <= '{start: 1'b1, steps: 5'd16,
                                         rem: ent_reg.tt[25:2],
                                         low: {ent_reg.tt[1:0], 22'd0},
                                         divisor: ent_reg.ff};
                        state_reg   <= ST_EWAIT;
                    end
                end
                ST_EWAIT: begin
                    div_req_reg.start <= 1'b0;
                    if (div_rsp.done) begin
                        ratio_reg <= div_rsp.quot[15:0];
                        state_reg <= ST_EMUL;
                    end
                end
                ST_EMUL: begin
                    up_reg    <= ratio_reg >= ent_reg.ema;
                    dlt_reg   <= dprod[31:16];
                    state_reg <= ST_EUPD;
                end
                ST_EUPD: begin
                    ent_reg.ema <= up_reg ? ent_reg.ema + dlt_reg : ent_reg.ema - dlt_reg;
                    state_reg   <= ST_WR;
                end
                ST_WR: begin
                    if (!walk_reg) begin
                        state_reg <= ST_OUT;
                    end else if (addr_reg == LAST_IDX) begin
                        walk_reg <= 1'b0;
                        if (inr_reg) begin
                            addr_reg  <= AW'(edge_reg);
                            state_reg <= ST_RD;
                        end else begin
                            state_reg <= ST_OUT;
                        end
                    end else begin
                        addr_reg  <= addr_reg + 1'b1;
                        state_reg <= ST_WRD;
                    end
                end
                ST_WRD: begin
                    state_reg <= ST_WGOT;
                end
                ST_WGOT: begin
                    ent_reg <= walk_ent;
                    if (!rdata.act) begin
                        // Idle link: nothing changes, move to the next one.
                        if (addr_reg == LAST_IDX) begin
                            walk_reg <= 1'b0;
                            if (inr_reg) begin
                                addr_reg  <= AW'(edge_reg);
                                state_reg <= ST_RD;
                            end else begin
                                state_reg <= ST_OUT;
                            end
                        end else begin
                            addr_reg  <= addr_reg + 1'b1;
                            state_reg <= ST_WRD;
                        end
                    end else if (rdata.occ == 16'd0) begin
                        // The emptied link already holds its free-flow time.
                        state_reg <= ST_EMA;
                    end else begin
                        state_reg <= ST_BPR;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_exit_reg  <= (kind_reg == KIND_ENTER) ? exit_sat : 40'd0;
                        m_tt_reg    <= inr_reg ? ent_reg.tt : 26'd256;
                        m_occ_reg   <= inr_reg ? ent_reg.occ : 16'd0;
                        m_ema_reg   <= inr_reg ? ent_reg.ema : 16'd0;
                        m_ev_reg    <= inr_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The result sits in its own register, so a new item is taken while the
    // previous result still waits for its transfer.
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_exit_time   = m_exit_reg;
    assign m_travel_time = m_tt_reg;
    assign m_occupancy   = m_occ_reg;
    assign m_cong_level  = m_ema_reg;
    assign m_edge_valid  = m_ev_reg;

    // An invalid link always reports one second and an empty, calm link.
    a_oor_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_edge_valid) |->
            (m_occupancy == 16'd0 && m_travel_time == 26'd256 && m_cong_level == 16'd0))
        else $error("invalid-link result carries table data");

    // The table is never written while waiting for an item.
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("table write while idle");

    // A divide is only requested when the shared divider is free.
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req_reg.start |-> !div_rsp.busy)
        else $error("divider started while busy");

endmodule
